>>> rtl/core/biz_pkg.sv
package biz_pkg;

   // Frame store geometry and fixed-point format
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int FRAC_BITS  = 16;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ROW_AW = $clog2(MAX_HEIGHT);
   localparam int COL_AW = $clog2(MAX_WIDTH);
   localparam int ADDR_W = $clog2(DEPTH);

   // Field widths
   localparam int IDX_W      = 10;
   localparam int IN_SIZE_W  = 10;
   localparam int OUT_SIZE_W = 11;
   localparam int STEP_W     = 24;
   localparam int PIX_W      = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Position datapath: d = 2*index - out_size, pos = size*2^FRAC + d*step
   localparam int D_W    = OUT_SIZE_W + 2;
   localparam int PROD_W = D_W + STEP_W + 1;
   localparam int POS_W  = PROD_W + 1;
   localparam int INT_W  = POS_W - FRAC_BITS - 2;

   // Blend datapath
   localparam int WT_W  = FRAC_BITS + 1;
   localparam int R0_W  = FRAC_BITS + PIX_W + 1;
   localparam int ACC_W = 2 * FRAC_BITS + PIX_W + 2;
   localparam int RND_W = ACC_W - 2 * FRAC_BITS;

   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [IN_SIZE_W-1:0]  in_size_type;
   typedef logic [OUT_SIZE_W-1:0] out_size_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [ROW_AW-1:0]     row_addr_type;
   typedef logic [COL_AW-1:0]     col_addr_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic signed [D_W-1:0]    d_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [INT_W-1:0]      int_type;
   typedef logic [INT_W:0]        cmp_type;
   typedef logic [FRAC_BITS-1:0]  frac_type;
   typedef logic [WT_W-1:0]       wt_type;
   typedef logic [R0_W-1:0]       r0_type;
   typedef logic [ACC_W-1:0]      acc_type;
   typedef logic [RND_W-1:0]      rnd_type;

   // Unit weight and rounding offset of the blend
   localparam wt_type  WT_ONE     = wt_type'(1) << FRAC_BITS;
   localparam acc_type ROUND_HALF = acc_type'(1) << (2 * FRAC_BITS - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_WIDTH   = 3'd0,
      CSR_IN_HEIGHT  = 3'd1,
      CSR_OUT_WIDTH  = 3'd2,
      CSR_OUT_HEIGHT = 3'd3,
      CSR_STEP_RATIO = 3'd4,
      CSR_FILL_VALUE = 3'd5
   } csr_index_type;

   typedef struct packed {
      in_size_type  in_width;
      in_size_type  in_height;
      out_size_type out_width;
      out_size_type out_height;
      step_type     step_ratio;
      pix_type      fill_value;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      in_width:   in_size_type'(416),
      in_height:  in_size_type'(416),
      out_width:  out_size_type'(832),
      out_height: out_size_type'(832),
      step_ratio: step_type'(32768),
      fill_value: pix_type'(0)
   };

   // One axis of the source position
   typedef struct packed {
      logic     outside;
      int_type  ipart;
      frac_type weight;
   } axis_type;

   // Source neighborhood of the current output pixel
   typedef struct packed {
      logic         outside;
      row_addr_type row;
      col_addr_type col;
      frac_type     dy;
      frac_type     dx;
   } loc_type;

   typedef struct packed {
      logic take00;
      logic sum0;
      logic take10;
      logic sum1;
      logic fin;
   } mix_ctl_type;

   function automatic addr_type pix_addr(input row_addr_type row, input col_addr_type col);
      return addr_type'(addr_type'(row) * addr_type'(MAX_WIDTH) + addr_type'(col));
   endfunction

endpackage

>>> rtl/core/biz_frame_store.sv
module biz_frame_store (
   input  logic               clock,
   input  logic               wr_en,
   input  biz_pkg::addr_type  addr,
   input  biz_pkg::pix_type   wr_data,
   output biz_pkg::pix_type   rd_data
);

   biz_pkg::pix_type store_mem [biz_pkg::DEPTH];
   biz_pkg::pix_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= wr_data;
      end
      rd_data_ff <= store_mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/biz_locate.sv
module biz_locate (
   input  logic              clock,
   input  logic              start,
   input  biz_pkg::idx_type  row_index,
   input  biz_pkg::idx_type  col_index,
   input  biz_pkg::cfg_type  cfg,
   output biz_pkg::loc_type  loc
);

   biz_pkg::d_type    d_row_ff, d_row_in, d_col_ff, d_col_in;
   biz_pkg::prod_type prod_row_ff, prod_row_in, prod_col_ff, prod_col_in;
   biz_pkg::loc_type  loc_ff, loc_in;
   biz_pkg::in_size_type size_h, size_w;
   biz_pkg::axis_type ax_row, ax_col;

   function automatic biz_pkg::axis_type axis_eval(input biz_pkg::in_size_type size_lim,
                                                   input biz_pkg::prod_type prod);
      biz_pkg::pos_type  pos;
      biz_pkg::axis_type res;
      pos = biz_pkg::pos_type'({prod[biz_pkg::PROD_W-1], prod})
          + (biz_pkg::pos_type'(size_lim) << biz_pkg::FRAC_BITS);
      res.ipart  = pos[biz_pkg::POS_W-2:biz_pkg::FRAC_BITS+1];
      res.weight = pos[biz_pkg::FRAC_BITS:1];
      // outside when negative or when floor + 2 exceeds the size
      res.outside = pos[biz_pkg::POS_W-1]
                  | (({1'b0, res.ipart} + biz_pkg::cmp_type'(2)) > biz_pkg::cmp_type'(size_lim));
      return res;
   endfunction

   always_comb begin
      size_h = (int'(cfg.in_height) > biz_pkg::MAX_HEIGHT)
             ? biz_pkg::in_size_type'(biz_pkg::MAX_HEIGHT) : cfg.in_height;
      size_w = (int'(cfg.in_width) > biz_pkg::MAX_WIDTH)
             ? biz_pkg::in_size_type'(biz_pkg::MAX_WIDTH) : cfg.in_width;

      d_row_in = d_row_ff;
      d_col_in = d_col_ff;
      if (start) begin
         d_row_in = biz_pkg::d_type'({row_index, 1'b0}) - biz_pkg::d_type'(cfg.out_height);
         d_col_in = biz_pkg::d_type'({col_index, 1'b0}) - biz_pkg::d_type'(cfg.out_width);
      end

      prod_row_in = d_row_ff * $signed({1'b0, cfg.step_ratio});
      prod_col_in = d_col_ff * $signed({1'b0, cfg.step_ratio});

      ax_row = axis_eval(size_h, prod_row_ff);
      ax_col = axis_eval(size_w, prod_col_ff);

      loc_in.outside = ax_row.outside | ax_col.outside;
      loc_in.row     = biz_pkg::row_addr_type'(ax_row.ipart);
      loc_in.col     = biz_pkg::col_addr_type'(ax_col.ipart);
      loc_in.dy      = ax_row.weight;
      loc_in.dx      = ax_col.weight;
   end

   always_ff @(posedge clock) begin
      d_row_ff    <= d_row_in;
      d_col_ff    <= d_col_in;
      prod_row_ff <= prod_row_in;
      prod_col_ff <= prod_col_in;
      loc_ff      <= loc_in;
   end

   assign loc = loc_ff;

endmodule

>>> rtl/core/biz_blend.sv
module biz_blend (
   input  logic                 clock,
   input  biz_pkg::mix_ctl_type ctl,
   input  biz_pkg::pix_type     rd_data,
   input  biz_pkg::frac_type    dx,
   input  biz_pkg::frac_type    dy,
   output biz_pkg::pix_type     pix
);

   biz_pkg::pix_type q00_ff, q00_in, q10_ff, q10_in;
   biz_pkg::r0_type  r0_ff, r0_in, r1_ff, r1_in;
   biz_pkg::pix_type pix_ff, pix_in;
   biz_pkg::wt_type  wx0, wx1, wy0, wy1;
   biz_pkg::r0_type  row_sum;
   biz_pkg::acc_type acc;
   biz_pkg::rnd_type rounded;
   biz_pkg::pix_type near_q;

   always_comb begin
      wx1 = biz_pkg::wt_type'(dx);
      wx0 = biz_pkg::WT_ONE - wx1;
      wy1 = biz_pkg::wt_type'(dy);
      wy0 = biz_pkg::WT_ONE - wy1;

      // left neighbor comes from the capture, right neighbor from the memory
      near_q  = ctl.sum1 ? q10_ff : q00_ff;
      row_sum = biz_pkg::r0_type'(wx0) * biz_pkg::r0_type'(near_q)
              + biz_pkg::r0_type'(wx1) * biz_pkg::r0_type'(rd_data);

      acc = biz_pkg::acc_type'(wy0) * biz_pkg::acc_type'(r0_ff)
          + biz_pkg::acc_type'(wy1) * biz_pkg::acc_type'(r1_ff) + biz_pkg::ROUND_HALF;
      rounded = acc[biz_pkg::ACC_W-1:2*biz_pkg::FRAC_BITS];

      q00_in = ctl.take00 ? rd_data : q00_ff;
      q10_in = ctl.take10 ? rd_data : q10_ff;
      r0_in  = ctl.sum0 ? row_sum : r0_ff;
      r1_in  = ctl.sum1 ? row_sum : r1_ff;
      pix_in = pix_ff;
      if (ctl.fin) begin
         // saturate at full scale
         pix_in = (rounded[biz_pkg::RND_W-1:biz_pkg::PIX_W] != '0)
                ? '1 : rounded[biz_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      q00_ff <= q00_in;
      q10_ff <= q10_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      pix_ff <= pix_in;
   end

   assign pix = pix_ff;

endmodule

>>> rtl/core/bilinear_image_zoom_top.sv
// Bilinear image zoom: scales an 8-bit grey image about its center.
// Channels:
//   req_*  input items. opcode store writes pixel_in into the frame store at
//          (row_index, col_index); compute asks for output pixel (row, col).
//   rsp_*  one result per compute: pixel_out and outside (fill value given).
//   csr_*  register writes (index, data); csr_ready is always high. Write
//          only while no compute is in flight.
// A transfer happens when valid is high and stall is low.
// A store leaves the block idle, so the next item is not held off. A compute
// steps through MUL and POS (the position multiply), RD00 to RD11 (the four
// neighbor reads through the single port of the frame store), MIX and FIN
// (the two-step blend) and DONE; req_stall stays high until it is back in
// IDLE. A source outside the image goes from RD00 straight to DONE.
// A finished result waits in the rsp register; while rsp_stall holds it,
// stores and a new compute are still accepted, and that compute waits in its
// last step until the register frees up.
// Reset forces IDLE and the default config and drops rsp_valid; the frame
// store keeps no reset and must be written before it is read.
module bilinear_image_zoom_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [biz_pkg::IDX_W-1:0]        req_row_index,
   input  logic [biz_pkg::IDX_W-1:0]        req_col_index,
   input  logic [biz_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [biz_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                             rsp_outside,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [biz_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [biz_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MUL  = 10'b0000000010,
      ST_POS  = 10'b0000000100,
      ST_RD00 = 10'b0000001000,
      ST_RD01 = 10'b0000010000,
      ST_RD10 = 10'b0000100000,
      ST_RD11 = 10'b0001000000,
      ST_MIX  = 10'b0010000000,
      ST_FIN  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   biz_pkg::cfg_type cfg_ff, cfg_in;
   logic rsp_valid_ff, rsp_valid_in;
   biz_pkg::pix_type rsp_pixel_ff, rsp_pixel_in;
   logic rsp_outside_ff, rsp_outside_in;

   logic req_accept, store_accept, start, store_in_range, rsp_free, rsp_load;
   biz_pkg::addr_type mem_addr;
   logic mem_wr_en;
   biz_pkg::pix_type mem_rd_data;
   biz_pkg::loc_type loc;
   biz_pkg::mix_ctl_type mix_ctl;
   biz_pkg::pix_type mix_pix;
   biz_pkg::row_addr_type row_next;
   biz_pkg::col_addr_type col_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   biz_locate u_locate (
      .clock     (clock),
      .start     (start),
      .row_index (req_row_index),
      .col_index (req_col_index),
      .cfg       (cfg_ff),
      .loc       (loc)
   );

   biz_frame_store u_frame_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (req_pixel_in),
      .rd_data (mem_rd_data)
   );

   biz_blend u_blend (
      .clock   (clock),
      .ctl     (mix_ctl),
      .rd_data (mem_rd_data),
      .dx      (loc.dx),
      .dy      (loc.dy),
      .pix     (mix_pix)
   );

   always_comb begin
      req_accept     = req_valid & ~req_stall;
      store_accept   = req_accept & (req_opcode == biz_pkg::OP_STORE);
      start          = req_accept & (req_opcode == biz_pkg::OP_COMPUTE);
      // drop stores that fall outside the frame
      store_in_range = (int'(req_row_index) < biz_pkg::MAX_HEIGHT)
                     & (int'(req_col_index) < biz_pkg::MAX_WIDTH);
      mem_wr_en      = store_accept & store_in_range;
      rsp_free       = ~rsp_valid_ff | ~rsp_stall;

      row_next = loc.row + biz_pkg::row_addr_type'(1);
      col_next = loc.col + biz_pkg::col_addr_type'(1);

      unique case (state_ff)
         ST_RD00: mem_addr = biz_pkg::pix_addr(loc.row, loc.col);
         ST_RD01: mem_addr = biz_pkg::pix_addr(loc.row, col_next);
         ST_RD10: mem_addr = biz_pkg::pix_addr(row_next, loc.col);
         ST_RD11: mem_addr = biz_pkg::pix_addr(row_next, col_next);
         default: mem_addr = biz_pkg::pix_addr(biz_pkg::row_addr_type'(req_row_index),
                                               biz_pkg::col_addr_type'(req_col_index));
      endcase

      // read data is registered, so it arrives in the cycle after its address
      mix_ctl.take00 = (state_ff == ST_RD01);
      mix_ctl.sum0   = (state_ff == ST_RD10);
      mix_ctl.take10 = (state_ff == ST_RD11);
      mix_ctl.sum1   = (state_ff == ST_MIX);
      mix_ctl.fin    = (state_ff == ST_FIN);

      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_MUL : ST_IDLE;
         ST_MUL:  state_in = ST_POS;
         ST_POS:  state_in = ST_RD00;
         ST_RD00: state_in = loc.outside ? ST_DONE : ST_RD01;
         ST_RD01: state_in = ST_RD10;
         ST_RD10: state_in = ST_RD11;
         ST_RD11: state_in = ST_MIX;
         ST_MIX:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: begin
            rsp_load = rsp_free;
            state_in = rsp_free ? ST_IDLE : ST_DONE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in   = rsp_load | (rsp_valid_ff & rsp_stall);
      rsp_pixel_in   = rsp_pixel_ff;
      rsp_outside_in = rsp_outside_ff;
      if (rsp_load) begin
         rsp_pixel_in   = loc.outside ? cfg_ff.fill_value : mix_pix;
         rsp_outside_in = loc.outside;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            biz_pkg::CSR_IN_WIDTH:   cfg_in.in_width   = biz_pkg::in_size_type'(csr_wdata);
            biz_pkg::CSR_IN_HEIGHT:  cfg_in.in_height  = biz_pkg::in_size_type'(csr_wdata);
            biz_pkg::CSR_OUT_WIDTH:  cfg_in.out_width  = biz_pkg::out_size_type'(csr_wdata);
            biz_pkg::CSR_OUT_HEIGHT: cfg_in.out_height = biz_pkg::out_size_type'(csr_wdata);
            biz_pkg::CSR_STEP_RATIO: cfg_in.step_ratio = biz_pkg::step_type'(csr_wdata);
            biz_pkg::CSR_FILL_VALUE: cfg_in.fill_value = biz_pkg::pix_type'(csr_wdata);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= biz_pkg::CFG_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_outside   = rsp_outside_ff;

endmodule
